// ===== design/svg_pkg.sv =====
// shared types, constants and sine table for the sprite quad vertex generator
`timescale 1ns / 1ps
package svg_pkg;

    localparam int SINE_DEPTH = 1024;
    localparam int IDX_W      = $clog2(SINE_DEPTH + 1);
    localparam int IDX_PROD_W = 14 + IDX_W;

    localparam int CFG_W   = 13;
    localparam int POS_W   = 19;
    localparam int SCALE_W = 16;
    localparam int ANGLE_W = 16;
    localparam int SIZE_W  = 12;
    localparam int UV_W    = 12;
    localparam int OUT_W   = 16;

    localparam int PROD_W = SIZE_W + SCALE_W;   // scaled half size, Q.9
    localparam int CEN_W  = 30;                 // signed centre, Q.9
    localparam int TRIG_W = 17;                 // signed Q1.15 sine/cosine
    localparam int DX_W   = PROD_W + 1;
    localparam int MUL_W  = TRIG_W + DX_W;
    localparam int SUM_W  = MUL_W + 1;
    localparam int X_W    = 32;
    localparam int N_W    = X_W + 6;
    localparam int TEXN_W = 26;

    localparam int NUM_W  = 30;                 // divider numerator
    localparam int DEN_W  = CFG_W + 1;          // divider denominator
    localparam int QUO_W  = OUT_W;              // divider quotient = pipeline depth

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam int ROUND_BIAS   = 16384;
    localparam int X_OFFSET_MUL = 57345;       // 1 + 2 * 28672
    localparam int Y_OFFSET_MUL = 57343;       // 1 + 2 * 28671
    localparam int LIM_SHIFT    = 17;          // 65536 * 2

    localparam logic [1:0] REG_SCREEN_W  = 2'd0;
    localparam logic [1:0] REG_SCREEN_H  = 2'd1;
    localparam logic [1:0] REG_TEXTURE_W = 2'd2;
    localparam logic [1:0] REG_TEXTURE_H = 2'd3;

    localparam logic [CFG_W-1:0] RST_SCREEN_W  = 13'd1280;
    localparam logic [CFG_W-1:0] RST_SCREEN_H  = 13'd720;
    localparam logic [CFG_W-1:0] RST_TEXTURE_W = 13'd256;
    localparam logic [CFG_W-1:0] RST_TEXTURE_H = 13'd256;

    localparam logic [1:0] CORNER_LAST = 2'd3;

    localparam logic [OUT_W-1:0] NDC_MIN  = 16'h8000;
    localparam logic [OUT_W-1:0] NDC_MAX  = 16'h7FFF;
    localparam logic [OUT_W-1:0] TEX_MAX  = 16'hFFFF;

    typedef logic [14:0] sine_tab_t [0:SINE_DEPTH];

    // shift-subtract long division, evaluated only while building the table
    function automatic longint unsigned udiv_const(longint unsigned n, longint unsigned d);
        longint unsigned q;
        longint unsigned rem;
        q = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = (rem << 1) | {63'b0, n[b]};
            if (rem >= d) begin
                rem = rem - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // quarter-wave sine in Q1.15 from a Q30 Taylor series
    function automatic sine_tab_t build_sine_tab();
        sine_tab_t tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint sum;
        longint r;
        for (int k = 0; k <= SINE_DEPTH; k++) begin
            x = udiv_const(longint'(k) * 64'd1686629713, 64'(SINE_DEPTH));
            x2 = (x * x) >> 30;
            term = x;
            sum = longint'(x);
            for (int i = 1; i < 16; i++) begin
                term = (term * x2) >> 30;
                term = udiv_const(term, 64'((2 * i) * (2 * i + 1)));
                if ((i & 1) == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            r = longint'((longint'(sum) * 64'd32767 + (64'd1 << 29)) >> 30);
            if (r > 32767) begin
                r = 32767;
            end
            tab[k] = r[14:0];
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

    typedef struct packed {
        logic signed [CEN_W-1:0]  cx;
        logic signed [CEN_W-1:0]  cy;
        logic [PROD_W-1:0]        sw;
        logic [PROD_W-1:0]        sh;
        logic signed [TRIG_W-1:0] s;
        logic signed [TRIG_W-1:0] c;
        logic [UV_W-1:0]          uv_x;
        logic [UV_W-1:0]          uv_y;
        logic [UV_W-1:0]          uv_w;
        logic [UV_W-1:0]          uv_h;
    } item_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] corner;
        logic       x_lo;
        logic       x_hi;
        logic       y_lo;
        logic       y_hi;
        logic       u_hi;
        logic       v_hi;
    } side_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic empty;
    } fifo_ctl_t;

endpackage

// ===== design/svg_div.sv =====
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module svg_div (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [svg_pkg::NUM_W-1:0]     num_in,
    input  logic [svg_pkg::DEN_W-1:0]     den_in,
    output logic [svg_pkg::QUO_W-1:0]     q_out
);

    logic [svg_pkg::NUM_W-1:0] rem_reg [0:svg_pkg::QUO_W-1];
    logic [svg_pkg::QUO_W-1:0] quo_reg [0:svg_pkg::QUO_W-1];

    // divisor is not staged: the user must hold it stable while work is in flight; not enforced here
    for (genvar j = 0; j < svg_pkg::QUO_W; j++) begin : g_stage
        logic [svg_pkg::NUM_W-1:0] rem_in;
        logic [svg_pkg::NUM_W-1:0] shifted;
        logic [svg_pkg::QUO_W-1:0] quo_in;
        logic                      take;

        if (j == 0) begin : g_first
            assign rem_in = num_in;
            assign quo_in = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign quo_in = quo_reg[j-1];
        end

        assign shifted = svg_pkg::NUM_W'(den_in) << (svg_pkg::QUO_W - 1 - j);
        assign take    = rem_in >= shifted;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j] <= take ? (rem_in - shifted) : rem_in;
                quo_reg[j] <= {quo_in[svg_pkg::QUO_W-2:0], take};
            end
        end
    end

    assign q_out = quo_reg[svg_pkg::QUO_W-1];

endmodule

// ===== design/svg_fifo.sv =====
// short request queue between the front and back parts
`timescale 1ns / 1ps
module svg_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  svg_pkg::fifo_ctl_t   ctl_in,
    input  svg_pkg::item_t       push_item,
    output logic                 full,
    output logic                 empty,
    output svg_pkg::item_t       head
);

    svg_pkg::item_t                 mem_reg [0:svg_pkg::FIFO_DEPTH-1];
    logic [svg_pkg::FIFO_AW-1:0]    wr_ptr_reg;
    logic [svg_pkg::FIFO_AW-1:0]    rd_ptr_reg;
    logic [svg_pkg::FIFO_AW:0]      count_reg;
    logic [svg_pkg::FIFO_AW:0]      count_next;

    assign full  = count_reg == (svg_pkg::FIFO_AW + 1)'(svg_pkg::FIFO_DEPTH);
    assign empty = count_reg == '0;
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (ctl_in.push && !ctl_in.pop) begin
            count_next = count_reg + 1'b1;
        end else if (!ctl_in.push && ctl_in.pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (ctl_in.push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (ctl_in.pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl_in.push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== design/svg_front.sv =====
// front part: takes sprite requests, drops hidden ones, scales size and looks up sine/cosine
`timescale 1ns / 1ps
module svg_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_visible,
    input  logic signed [svg_pkg::POS_W-1:0]  s_pos_x,
    input  logic signed [svg_pkg::POS_W-1:0]  s_pos_y,
    input  logic [svg_pkg::SCALE_W-1:0]       s_scale_x,
    input  logic [svg_pkg::SCALE_W-1:0]       s_scale_y,
    input  logic [svg_pkg::ANGLE_W-1:0]       s_angle,
    input  logic [svg_pkg::SIZE_W-1:0]        s_size_w,
    input  logic [svg_pkg::SIZE_W-1:0]        s_size_h,
    input  logic [svg_pkg::UV_W-1:0]          s_uv_x,
    input  logic [svg_pkg::UV_W-1:0]          s_uv_y,
    input  logic [svg_pkg::UV_W-1:0]          s_uv_w,
    input  logic [svg_pkg::UV_W-1:0]          s_uv_h,
    input  logic                              fifo_full,
    output logic                              push,
    output svg_pkg::item_t                    push_item
);

    logic                               en;
    logic                               s1_v_reg;
    logic                               s2_v_reg;
    logic [svg_pkg::PROD_W-1:0]         sw1_reg;
    logic [svg_pkg::PROD_W-1:0]         sh1_reg;
    logic signed [svg_pkg::POS_W-1:0]   px1_reg;
    logic signed [svg_pkg::POS_W-1:0]   py1_reg;
    logic [1:0]                         quad1_reg;
    logic [svg_pkg::IDX_W-1:0]          idx1_reg;
    logic [svg_pkg::UV_W-1:0]           uvx1_reg;
    logic [svg_pkg::UV_W-1:0]           uvy1_reg;
    logic [svg_pkg::UV_W-1:0]           uvw1_reg;
    logic [svg_pkg::UV_W-1:0]           uvh1_reg;
    logic [svg_pkg::IDX_PROD_W-1:0]     idx_prod;
    logic [14:0]                        t_near;
    logic [14:0]                        t_far;
    logic signed [svg_pkg::TRIG_W-1:0]  pn;
    logic signed [svg_pkg::TRIG_W-1:0]  pf;
    logic signed [svg_pkg::TRIG_W-1:0]  sin_val;
    logic signed [svg_pkg::TRIG_W-1:0]  cos_val;
    svg_pkg::item_t                     item2_reg;
    svg_pkg::item_t                     item2_next;

    assign en      = !s2_v_reg || !fifo_full;
    assign s_ready = en;
    assign push    = s2_v_reg && !fifo_full;
    assign push_item = item2_reg;

    assign idx_prod = svg_pkg::IDX_PROD_W'(s_angle[13:0])
                    * svg_pkg::IDX_PROD_W'(svg_pkg::SINE_DEPTH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end else if (en) begin
            s1_v_reg <= s_valid && s_visible;
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sw1_reg   <= svg_pkg::PROD_W'(s_size_w) * svg_pkg::PROD_W'(s_scale_x);
            sh1_reg   <= svg_pkg::PROD_W'(s_size_h) * svg_pkg::PROD_W'(s_scale_y);
            px1_reg   <= s_pos_x;
            py1_reg   <= s_pos_y;
            quad1_reg <= s_angle[15:14];
            idx1_reg  <= svg_pkg::IDX_W'(idx_prod >> 14);
            uvx1_reg  <= s_uv_x;
            uvy1_reg  <= s_uv_y;
            uvw1_reg  <= s_uv_w;
            uvh1_reg  <= s_uv_h;
        end
    end

    assign t_near = svg_pkg::SINE_TAB[idx1_reg];
    assign t_far  = svg_pkg::SINE_TAB[svg_pkg::IDX_W'(svg_pkg::SINE_DEPTH) - idx1_reg];
    assign pn = $signed({2'b00, t_near});
    assign pf = $signed({2'b00, t_far});

    // cosine is the sine one quadrant ahead
    always_comb begin
        case (quad1_reg)
            2'd0: begin
                sin_val = pn;
                cos_val = pf;
            end
            2'd1: begin
                sin_val = pf;
                cos_val = -pn;
            end
            2'd2: begin
                sin_val = -pn;
                cos_val = -pf;
            end
            default: begin
                sin_val = -pf;
                cos_val = pn;
            end
        endcase
    end

    always_comb begin
        item2_next.cx = $signed({{(svg_pkg::CEN_W - svg_pkg::POS_W - 5){px1_reg[svg_pkg::POS_W-1]}},
                                 px1_reg, 5'b0})
                      + $signed({{(svg_pkg::CEN_W - svg_pkg::PROD_W){1'b0}}, sw1_reg});
        item2_next.cy = $signed({{(svg_pkg::CEN_W - svg_pkg::POS_W - 5){py1_reg[svg_pkg::POS_W-1]}},
                                 py1_reg, 5'b0})
                      + $signed({{(svg_pkg::CEN_W - svg_pkg::PROD_W){1'b0}}, sh1_reg});
        item2_next.sw   = sw1_reg;
        item2_next.sh   = sh1_reg;
        item2_next.s    = sin_val;
        item2_next.c    = cos_val;
        item2_next.uv_x = uvx1_reg;
        item2_next.uv_y = uvy1_reg;
        item2_next.uv_w = uvw1_reg;
        item2_next.uv_h = uvh1_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item2_reg <= item2_next;
        end
    end

endmodule

// ===== design/svg_back.sv =====
// back part: config registers, per-corner rotation, device and texture mapping, output register
`timescale 1ns / 1ps
module svg_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [1:0]                         cfg_index,
    input  logic [svg_pkg::CFG_W-1:0]          cfg_data,
    input  svg_pkg::item_t                     head,
    input  logic                               fifo_empty,
    output logic                               pop,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [1:0]                         m_corner,
    output logic signed [svg_pkg::OUT_W-1:0]   m_x_ndc,
    output logic signed [svg_pkg::OUT_W-1:0]   m_y_ndc,
    output logic [svg_pkg::OUT_W-1:0]          m_tex_u,
    output logic [svg_pkg::OUT_W-1:0]          m_tex_v,
    output logic                               m_last
);

    localparam int OFF_W = svg_pkg::CFG_W + 16;
    localparam int LIM_W = svg_pkg::CFG_W + svg_pkg::LIM_SHIFT;

    logic [svg_pkg::CFG_W-1:0] scr_w_reg, scr_h_reg, tex_w_reg, tex_h_reg;
    logic [svg_pkg::CFG_W-1:0] w_nz, h_nz, tw_nz, th_nz;
    logic [OFF_W-1:0]          off_x_reg, off_y_reg;
    logic [LIM_W-1:0]          lim_x_reg, lim_y_reg, lim_u_reg, lim_v_reg;
    logic [svg_pkg::DEN_W-1:0] den_x_reg, den_y_reg, den_u_reg, den_v_reg;
    logic [svg_pkg::CFG_W-1:0] tw_reg, th_reg;

    logic       en;
    logic       issue;
    logic [1:0] corner_reg;

    // stage 1
    logic                               b1_v_reg;
    logic [1:0]                         b1_corner_reg;
    logic signed [svg_pkg::CEN_W-1:0]   b1_cx_reg, b1_cy_reg;
    logic signed [svg_pkg::MUL_W-1:0]   p_cdx_reg, p_sdy_reg, p_sdx_reg, p_cdy_reg;
    logic [svg_pkg::TEXN_W-1:0]         nu_reg, nv_reg;
    logic signed [svg_pkg::DX_W-1:0]    dx, dy;
    logic [svg_pkg::CFG_W-1:0]          t_u, t_v;

    // stage 2
    logic                               b2_v_reg;
    logic [1:0]                         b2_corner_reg;
    logic signed [svg_pkg::X_W-1:0]     x_reg, y_reg;
    logic [svg_pkg::TEXN_W-1:0]         nu2_reg, nv2_reg;
    logic signed [svg_pkg::SUM_W-1:0]   sum_x, sum_y;

    // stage 3
    svg_pkg::side_t                     b3_side_reg;
    svg_pkg::side_t                     b3_side_next;
    logic [svg_pkg::NUM_W-1:0]          num_x_reg, num_y_reg, num_u_reg, num_v_reg;
    logic signed [svg_pkg::N_W-1:0]     nx, ny;

    svg_pkg::side_t                     side_reg [0:svg_pkg::QUO_W-1];
    logic [svg_pkg::QUO_W-1:0]          q_x, q_y, q_u, q_v;
    svg_pkg::side_t                     sd;

    logic m_valid_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scr_w_reg <= svg_pkg::RST_SCREEN_W;
            scr_h_reg <= svg_pkg::RST_SCREEN_H;
            tex_w_reg <= svg_pkg::RST_TEXTURE_W;
            tex_h_reg <= svg_pkg::RST_TEXTURE_H;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                svg_pkg::REG_SCREEN_W:  scr_w_reg <= cfg_data;
                svg_pkg::REG_SCREEN_H:  scr_h_reg <= cfg_data;
                svg_pkg::REG_TEXTURE_W: tex_w_reg <= cfg_data;
                svg_pkg::REG_TEXTURE_H: tex_h_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // a zero size acts as one
    assign w_nz  = (scr_w_reg == '0) ? svg_pkg::CFG_W'(1) : scr_w_reg;
    assign h_nz  = (scr_h_reg == '0) ? svg_pkg::CFG_W'(1) : scr_h_reg;
    assign tw_nz = (tex_w_reg == '0) ? svg_pkg::CFG_W'(1) : tex_w_reg;
    assign th_nz = (tex_h_reg == '0) ? svg_pkg::CFG_W'(1) : tex_h_reg;

    // derived divisor terms, registered from the size registers
    always_ff @(posedge aclk) begin
        off_x_reg <= OFF_W'(w_nz) * OFF_W'(svg_pkg::X_OFFSET_MUL);
        off_y_reg <= OFF_W'(h_nz) * OFF_W'(svg_pkg::Y_OFFSET_MUL);
        lim_x_reg <= {w_nz, {svg_pkg::LIM_SHIFT{1'b0}}};
        lim_y_reg <= {h_nz, {svg_pkg::LIM_SHIFT{1'b0}}};
        lim_u_reg <= {tw_nz, {svg_pkg::LIM_SHIFT{1'b0}}};
        lim_v_reg <= {th_nz, {svg_pkg::LIM_SHIFT{1'b0}}};
        den_x_reg <= {w_nz, 1'b0};
        den_y_reg <= {h_nz, 1'b0};
        den_u_reg <= {tw_nz, 1'b0};
        den_v_reg <= {th_nz, 1'b0};
        tw_reg    <= tw_nz;
        th_reg    <= th_nz;
    end

    assign en    = !m_valid_reg || m_ready;
    assign issue = !fifo_empty && en;
    assign pop   = issue && (corner_reg == svg_pkg::CORNER_LAST);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            corner_reg <= '0;
        end else if (issue) begin
            corner_reg <= corner_reg + 1'b1;
        end
    end

    // stage 1: corner offsets, rotation products and texture numerators
    assign dx = corner_reg[0] ? $signed({1'b0, head.sw}) : -$signed({1'b0, head.sw});
    assign dy = corner_reg[1] ? $signed({1'b0, head.sh}) : -$signed({1'b0, head.sh});
    assign t_u = corner_reg[0] ? (svg_pkg::CFG_W'(head.uv_x) + svg_pkg::CFG_W'(head.uv_w))
                               : svg_pkg::CFG_W'(head.uv_x);
    assign t_v = corner_reg[1] ? (svg_pkg::CFG_W'(head.uv_y) + svg_pkg::CFG_W'(head.uv_h))
                               : svg_pkg::CFG_W'(head.uv_y);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_v_reg <= 1'b0;
            b2_v_reg <= 1'b0;
        end else if (en) begin
            b1_v_reg <= issue;
            b2_v_reg <= b1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b1_corner_reg <= corner_reg;
            b1_cx_reg     <= head.cx;
            b1_cy_reg     <= head.cy;
            p_cdx_reg     <= head.c * dx;
            p_sdy_reg     <= head.s * dy;
            p_sdx_reg     <= head.s * dx;
            p_cdy_reg     <= head.c * dy;
            nu_reg        <= {t_u, 13'b0} + svg_pkg::TEXN_W'(tw_reg);
            nv_reg        <= {t_v, 13'b0} + svg_pkg::TEXN_W'(th_reg);
        end
    end

    // stage 2: rounded rotation added to the centre
    assign sum_x = svg_pkg::SUM_W'(p_cdx_reg) - svg_pkg::SUM_W'(p_sdy_reg)
                 + svg_pkg::SUM_W'(svg_pkg::ROUND_BIAS);
    assign sum_y = svg_pkg::SUM_W'(p_sdx_reg) + svg_pkg::SUM_W'(p_cdy_reg)
                 + svg_pkg::SUM_W'(svg_pkg::ROUND_BIAS);

    always_ff @(posedge aclk) begin
        if (en) begin
            b2_corner_reg <= b1_corner_reg;
            x_reg   <= svg_pkg::X_W'(b1_cx_reg) + svg_pkg::X_W'(sum_x >>> 15);
            y_reg   <= svg_pkg::X_W'(b1_cy_reg) + svg_pkg::X_W'(sum_y >>> 15);
            nu2_reg <= nu_reg;
            nv2_reg <= nv_reg;
        end
    end

    // stage 3: offset numerators so the quotient lands in 0..65535, flag saturation
    assign nx = (svg_pkg::N_W'(x_reg) <<< 5) + $signed(svg_pkg::N_W'(off_x_reg));
    assign ny = (svg_pkg::N_W'(y_reg) <<< 5) + $signed(svg_pkg::N_W'(off_y_reg));

    always_comb begin
        b3_side_next.valid  = b2_v_reg;
        b3_side_next.corner = b2_corner_reg;
        b3_side_next.x_lo   = nx[svg_pkg::N_W-1];
        b3_side_next.x_hi   = !nx[svg_pkg::N_W-1]
                            && (nx[svg_pkg::N_W-2:0] >= (svg_pkg::N_W-1)'(lim_x_reg));
        b3_side_next.y_lo   = ny[svg_pkg::N_W-1];
        b3_side_next.y_hi   = !ny[svg_pkg::N_W-1]
                            && (ny[svg_pkg::N_W-2:0] >= (svg_pkg::N_W-1)'(lim_y_reg));
        b3_side_next.u_hi   = LIM_W'(nu2_reg) >= lim_u_reg;
        b3_side_next.v_hi   = LIM_W'(nv2_reg) >= lim_v_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b3_side_reg <= '0;
        end else if (en) begin
            b3_side_reg <= b3_side_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_x_reg <= nx[svg_pkg::NUM_W-1:0];
            num_y_reg <= ny[svg_pkg::NUM_W-1:0];
            num_u_reg <= svg_pkg::NUM_W'(nu2_reg);
            num_v_reg <= svg_pkg::NUM_W'(nv2_reg);
        end
    end

    svg_div u_div_x (.aclk(aclk), .en(en), .num_in(num_x_reg), .den_in(den_x_reg), .q_out(q_x));
    svg_div u_div_y (.aclk(aclk), .en(en), .num_in(num_y_reg), .den_in(den_y_reg), .q_out(q_y));
    svg_div u_div_u (.aclk(aclk), .en(en), .num_in(num_u_reg), .den_in(den_u_reg), .q_out(q_u));
    svg_div u_div_v (.aclk(aclk), .en(en), .num_in(num_v_reg), .den_in(den_v_reg), .q_out(q_v));

    // side info follows the divider pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < svg_pkg::QUO_W; j++) begin
                side_reg[j] <= '0;
            end
        end else if (en) begin
            side_reg[0] <= b3_side_reg;
            for (int j = 1; j < svg_pkg::QUO_W; j++) begin
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    assign sd = side_reg[svg_pkg::QUO_W-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= sd.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_corner <= sd.corner;
            m_last   <= sd.corner == svg_pkg::CORNER_LAST;
            m_x_ndc  <= sd.x_lo ? svg_pkg::NDC_MIN
                      : (sd.x_hi ? svg_pkg::NDC_MAX : (q_x ^ svg_pkg::NDC_MIN));
            m_y_ndc  <= sd.y_lo ? svg_pkg::NDC_MAX
                      : (sd.y_hi ? svg_pkg::NDC_MIN : (q_y ^ svg_pkg::NDC_MAX));
            m_tex_u  <= sd.u_hi ? svg_pkg::TEX_MAX : q_u;
            m_tex_v  <= sd.v_hi ? svg_pkg::TEX_MAX : q_v;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== design/sprite_quad_vertex_generator.sv =====
// top level of the sprite quad vertex generator
//
// s_* channel: one sprite request per handshake (valid/ready). a visible sprite
// produces four vertex requests on the m_* channel in the order top-left,
// top-right, bottom-left, bottom-right, m_last marking the fourth. a hidden
// sprite is accepted and produces nothing.
// cfg_* port: plain write of screen and texture sizes, one register per cycle;
// the user must write only while the block is idle; the block does not enforce it.
// an accepted sprite reaches its first vertex through two front stages, the
// queue, three rotation/mapping stages, the 16-stage divider pipelines and the
// output register. while the receiver does not stall, one vertex per cycle;
// hidden sprites are taken one per cycle while the front is not held. the back
// part steps one corner per cycle unless the queue is empty or the output stalls.
// reset clears the queue and pipelines and loads 1280x720 screen, 256x256 texture.
// when the receiver stalls the back pipeline holds; the front keeps taking
// sprites until the 4-entry queue fills, then drops s_ready.
`timescale 1ns / 1ps
module sprite_quad_vertex_generator (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [1:0]                        cfg_index,
    input  logic [svg_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_visible,
    input  logic signed [svg_pkg::POS_W-1:0]  s_pos_x,
    input  logic signed [svg_pkg::POS_W-1:0]  s_pos_y,
    input  logic [svg_pkg::SCALE_W-1:0]       s_scale_x,
    input  logic [svg_pkg::SCALE_W-1:0]       s_scale_y,
    input  logic [svg_pkg::ANGLE_W-1:0]       s_angle,
    input  logic [svg_pkg::SIZE_W-1:0]        s_size_w,
    input  logic [svg_pkg::SIZE_W-1:0]        s_size_h,
    input  logic [svg_pkg::UV_W-1:0]          s_uv_x,
    input  logic [svg_pkg::UV_W-1:0]          s_uv_y,
    input  logic [svg_pkg::UV_W-1:0]          s_uv_w,
    input  logic [svg_pkg::UV_W-1:0]          s_uv_h,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_corner,
    output logic signed [svg_pkg::OUT_W-1:0]  m_x_ndc,
    output logic signed [svg_pkg::OUT_W-1:0]  m_y_ndc,
    output logic [svg_pkg::OUT_W-1:0]         m_tex_u,
    output logic [svg_pkg::OUT_W-1:0]         m_tex_v,
    output logic                              m_last
);

    svg_pkg::fifo_ctl_t fifo_ctl;
    svg_pkg::item_t     push_item;
    svg_pkg::item_t     head;
    logic               push;
    logic               pop;
    logic               full;
    logic               empty;

    always_comb begin
        fifo_ctl.push  = push;
        fifo_ctl.pop   = pop;
        fifo_ctl.full  = full;
        fifo_ctl.empty = empty;
    end

    svg_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_visible (s_visible),
        .s_pos_x   (s_pos_x),
        .s_pos_y   (s_pos_y),
        .s_scale_x (s_scale_x),
        .s_scale_y (s_scale_y),
        .s_angle   (s_angle),
        .s_size_w  (s_size_w),
        .s_size_h  (s_size_h),
        .s_uv_x    (s_uv_x),
        .s_uv_y    (s_uv_y),
        .s_uv_w    (s_uv_w),
        .s_uv_h    (s_uv_h),
        .fifo_full (fifo_ctl.full),
        .push      (push),
        .push_item (push_item)
    );

    svg_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl_in    (fifo_ctl),
        .push_item (push_item),
        .full      (full),
        .empty     (empty),
        .head      (head)
    );

    svg_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .head       (head),
        .fifo_empty (fifo_ctl.empty),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_corner   (m_corner),
        .m_x_ndc    (m_x_ndc),
        .m_y_ndc    (m_y_ndc),
        .m_tex_u    (m_tex_u),
        .m_tex_v    (m_tex_v),
        .m_last     (m_last)
    );

endmodule

// ===== tb/tb_sprite_quad_vertex_generator.sv =====
// testbench for the sprite quad vertex generator: directed and random sprites checked against a vertex predictor
`timescale 1ns / 1ps
module tb_sprite_quad_vertex_generator;

    typedef struct {
        logic                              visible;
        logic signed [svg_pkg::POS_W-1:0]  pos_x;
        logic signed [svg_pkg::POS_W-1:0]  pos_y;
        logic [svg_pkg::SCALE_W-1:0]       scale_x;
        logic [svg_pkg::SCALE_W-1:0]       scale_y;
        logic [svg_pkg::ANGLE_W-1:0]       angle;
        logic [svg_pkg::SIZE_W-1:0]        size_w;
        logic [svg_pkg::SIZE_W-1:0]        size_h;
        logic [svg_pkg::UV_W-1:0]          uv_x;
        logic [svg_pkg::UV_W-1:0]          uv_y;
        logic [svg_pkg::UV_W-1:0]          uv_w;
        logic [svg_pkg::UV_W-1:0]          uv_h;
    } sprite_t;

    typedef struct {
        logic [1:0]                       corner;
        logic signed [svg_pkg::OUT_W-1:0] x_ndc;
        logic signed [svg_pkg::OUT_W-1:0] y_ndc;
        logic [svg_pkg::OUT_W-1:0]        tex_u;
        logic [svg_pkg::OUT_W-1:0]        tex_v;
        logic                             last;
    } vertex_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_wr_en = 0;
    logic [1:0] cfg_index = svg_pkg::REG_SCREEN_W;
    logic [svg_pkg::CFG_W-1:0] cfg_data = '0;
    logic s_valid = 0;
    logic s_ready;
    logic s_visible = 0;
    logic signed [svg_pkg::POS_W-1:0] s_pos_x = '0;
    logic signed [svg_pkg::POS_W-1:0] s_pos_y = '0;
    logic [svg_pkg::SCALE_W-1:0] s_scale_x = '0;
    logic [svg_pkg::SCALE_W-1:0] s_scale_y = '0;
    logic [svg_pkg::ANGLE_W-1:0] s_angle = '0;
    logic [svg_pkg::SIZE_W-1:0] s_size_w = '0;
    logic [svg_pkg::SIZE_W-1:0] s_size_h = '0;
    logic [svg_pkg::UV_W-1:0] s_uv_x = '0;
    logic [svg_pkg::UV_W-1:0] s_uv_y = '0;
    logic [svg_pkg::UV_W-1:0] s_uv_w = '0;
    logic [svg_pkg::UV_W-1:0] s_uv_h = '0;
    logic m_valid;
    logic m_ready = 0;
    logic [1:0] m_corner;
    logic signed [svg_pkg::OUT_W-1:0] m_x_ndc;
    logic signed [svg_pkg::OUT_W-1:0] m_y_ndc;
    logic [svg_pkg::OUT_W-1:0] m_tex_u;
    logic [svg_pkg::OUT_W-1:0] m_tex_v;
    logic m_last;

    sprite_t pending_sprites[$];
    vertex_t expected_vertices[$];
    sprite_t cur_sprite;
    longint sine_lut [0:svg_pkg::SINE_DEPTH];
    logic [svg_pkg::CFG_W-1:0] reg_shadow [0:3];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    int cycle_count = 0;

    sprite_quad_vertex_generator uut (.*);

    always #10 aclk = ~aclk;

    function automatic longint fdiv(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q--;
        return q;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint reg_div(logic [svg_pkg::CFG_W-1:0] r);
        return r == 0 ? 1 : longint'(r);
    endfunction

    function automatic longint bam_sine(logic [15:0] a);
        longint i;
        longint v;
        i = longint'(a[13:0]) * svg_pkg::SINE_DEPTH / 16384;
        v = a[14] ? sine_lut[svg_pkg::SINE_DEPTH - i] : sine_lut[i];
        return a[15] ? -v : v;
    endfunction

    function automatic longint unsigned tex_norm(longint t, logic [svg_pkg::CFG_W-1:0] r);
        longint d;
        d = reg_div(r);
        return clip(fdiv(8192 * t + d, 2 * d), 0, 65535);
    endfunction

    // four corners of a visible sprite, TL TR BL BR
    task automatic predict_quad(sprite_t sp);
        longint sw, sh, cx, cy, sn, cs, w, h, dx, dy, rx, ry;
        vertex_t v;
        if (!sp.visible) return;
        sw = longint'(sp.size_w) * longint'(sp.scale_x);
        sh = longint'(sp.size_h) * longint'(sp.scale_y);
        cx = longint'(sp.pos_x) * 32 + sw;
        cy = longint'(sp.pos_y) * 32 + sh;
        sn = bam_sine(sp.angle);
        cs = bam_sine(sp.angle + 16'd16384);
        w = reg_div(reg_shadow[svg_pkg::REG_SCREEN_W]);
        h = reg_div(reg_shadow[svg_pkg::REG_SCREEN_H]);
        for (int k = 0; k < 4; k++) begin
            dx = k[0] ? sw : -sw;
            dy = k[1] ? sh : -sh;
            rx = fdiv(cs * dx - sn * dy + svg_pkg::ROUND_BIAS, 32768);
            ry = fdiv(sn * dx + cs * dy + svg_pkg::ROUND_BIAS, 32768);
            v.corner = k[1:0];
            v.x_ndc = clip(fdiv(32 * (cx + rx) + w, 2 * w) - 4096, -32768, 32767);
            v.y_ndc = clip(4096 - fdiv(32 * (cy + ry) + h, 2 * h), -32768, 32767);
            v.tex_u = tex_norm(k[0] ? longint'(sp.uv_x) + sp.uv_w : longint'(sp.uv_x),
                               reg_shadow[svg_pkg::REG_TEXTURE_W]);
            v.tex_v = tex_norm(k[1] ? longint'(sp.uv_y) + sp.uv_h : longint'(sp.uv_y),
                               reg_shadow[svg_pkg::REG_TEXTURE_H]);
            v.last = (k[1:0] == svg_pkg::CORNER_LAST);
            expected_vertices.push_back(v);
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) predict_quad(cur_sprite);
            if (!s_valid || s_ready) begin
                if (pending_sprites.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_sprite = pending_sprites.pop_front();
                    s_visible <= cur_sprite.visible;
                    s_pos_x <= cur_sprite.pos_x;
                    s_pos_y <= cur_sprite.pos_y;
                    s_scale_x <= cur_sprite.scale_x;
                    s_scale_y <= cur_sprite.scale_y;
                    s_angle <= cur_sprite.angle;
                    s_size_w <= cur_sprite.size_w;
                    s_size_h <= cur_sprite.size_h;
                    s_uv_x <= cur_sprite.uv_x;
                    s_uv_y <= cur_sprite.uv_y;
                    s_uv_w <= cur_sprite.uv_w;
                    s_uv_h <= cur_sprite.uv_h;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        vertex_t e;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_vertices.size() == 0) begin
                    $display("%0t: unexpected vertex corner %0d x %0d y %0d", $time,
                             m_corner, m_x_ndc, m_y_ndc);
                    error_count++;
                end else begin
                    e = expected_vertices.pop_front();
                    if (m_corner !== e.corner || m_x_ndc !== e.x_ndc ||
                        m_y_ndc !== e.y_ndc || m_tex_u !== e.tex_u ||
                        m_tex_v !== e.tex_v || m_last !== e.last) begin
                        $display("%0t: expected c%0d x %0d y %0d u %0d v %0d l %0d",
                                 $time, e.corner, e.x_ndc, e.y_ndc, e.tex_u, e.tex_v,
                                 e.last);
                        $display("%0t:   actual c%0d x %0d y %0d u %0d v %0d l %0d",
                                 $time, m_corner, m_x_ndc, m_y_ndc, m_tex_u, m_tex_v,
                                 m_last);
                        error_count++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > 300000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic sprite_t rand_sprite(bit full);
        sprite_t sp;
        sp.visible = full ? $urandom_range(1) : ($urandom_range(9) != 0);
        sp.pos_x = full ? $urandom : $urandom_range(40000) - 8000;
        sp.pos_y = full ? $urandom : $urandom_range(30000) - 8000;
        sp.scale_x = full ? $urandom : $urandom_range(1024);
        sp.scale_y = full ? $urandom : $urandom_range(1024);
        sp.angle = $urandom;
        sp.size_w = full ? $urandom : $urandom_range(300);
        sp.size_h = full ? $urandom : $urandom_range(300);
        sp.uv_x = full ? $urandom : $urandom_range(512);
        sp.uv_y = full ? $urandom : $urandom_range(512);
        sp.uv_w = full ? $urandom : $urandom_range(256);
        sp.uv_h = full ? $urandom : $urandom_range(256);
        return sp;
    endfunction

    // sample on the falling edge so the driver's updates have settled
    task automatic wait_drained();
        while (pending_sprites.size() > 0 || s_valid || expected_vertices.size() > 0)
            @(negedge aclk);
        // hidden sprites may still be in the front stages
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_sizes(int sw, int sh, int tw, int th);
        int vals [4];
        vals = '{sw, sh, tw, th};
        for (int r = 0; r < 4; r++) begin
            @(posedge aclk);
            cfg_wr_en <= 1'b1;
            cfg_index <= r[1:0];
            cfg_data <= vals[r][svg_pkg::CFG_W-1:0];
            reg_shadow[r] = vals[r][svg_pkg::CFG_W-1:0];
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic add_sprite(bit vis, int px, int py, int sx, int sy, int ang,
                              int w, int h, int ux, int uy, int uw, int uh);
        sprite_t sp;
        sp.visible = vis; sp.pos_x = px; sp.pos_y = py;
        sp.scale_x = sx; sp.scale_y = sy; sp.angle = ang;
        sp.size_w = w; sp.size_h = h;
        sp.uv_x = ux; sp.uv_y = uy; sp.uv_w = uw; sp.uv_h = uh;
        pending_sprites.push_back(sp);
    endtask

    initial begin
        longint unsigned x, x2, term;
        longint sum, r;
        int idle_modes [5][2];
        for (int k = 0; k <= svg_pkg::SINE_DEPTH; k++) begin
            x = longint'(k) * 64'd1686629713 / longint'(svg_pkg::SINE_DEPTH);
            x2 = (x * x) >> 30;
            term = x;
            sum = longint'(x);
            for (int i = 1; i < 16; i++) begin
                term = ((term * x2) >> 30) / longint'((2 * i) * (2 * i + 1));
                sum = (i % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
            end
            if (sum < 0) sum = 0;
            r = longint'((longint'(sum) * 64'd32767 + (64'd1 << 29)) >> 30);
            sine_lut[k] = r > 32767 ? 32767 : r;
        end
        reg_shadow[svg_pkg::REG_SCREEN_W] = svg_pkg::RST_SCREEN_W;
        reg_shadow[svg_pkg::REG_SCREEN_H] = svg_pkg::RST_SCREEN_H;
        reg_shadow[svg_pkg::REG_TEXTURE_W] = svg_pkg::RST_TEXTURE_W;
        reg_shadow[svg_pkg::REG_TEXTURE_H] = svg_pkg::RST_TEXTURE_H;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset sizes, no idling
        add_sprite(1, 0, 0, 256, 256, 0, 64, 32, 0, 0, 64, 32);
        add_sprite(1, 1600, 800, 256, 256, 16384, 100, 50, 10, 20, 30, 40);
        add_sprite(1, 1600, 800, 512, 128, 32768, 100, 50, 10, 20, 30, 40);
        add_sprite(1, 1600, 800, 256, 256, 49152, 100, 50, 10, 20, 30, 40);
        add_sprite(1, 1600, 800, 256, 256, 65535, 100, 50, 10, 20, 30, 40);
        add_sprite(1, 1600, 800, 256, 256, 8192, 100, 50, 10, 20, 30, 40);
        add_sprite(0, 1600, 800, 256, 256, 0, 100, 50, 10, 20, 30, 40);
        add_sprite(1, -262144, -262144, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_sprite(1, 262143, 262143, 65535, 65535, 12345, 4095, 4095,
                   4095, 4095, 4095, 4095);
        add_sprite(1, -262144, 262143, 65535, 0, 40000, 4095, 0, 4095, 0, 0, 4095);
        add_sprite(1, 500, 500, 0, 256, 0, 4095, 10, 100, 100, 0, 0);
        add_sprite(0, -262144, 262143, 65535, 65535, 65535, 4095, 4095,
                   4095, 4095, 4095, 4095);
        add_sprite(1, 0, 0, 256, 256, 0, 1280, 720, 0, 0, 256, 256);

        idle_modes = '{'{0, 0}, '{53, 0}, '{0, 53}, '{30, 30}, '{0, 0}};
        for (int ph = 0; ph < 7; ph++) begin
            wait_drained();
            case (ph)
                0: write_sizes(1, 1, 1, 1);
                1: write_sizes(0, 0, 0, 0);
                2: write_sizes(8191, 8191, 8191, 8191);
                3: write_sizes(4096, 4096, 4096, 4096);
                4: write_sizes(1920, 1080, 64, 512);
                5: write_sizes($urandom_range(8191), $urandom_range(8191),
                               $urandom_range(8191), $urandom_range(8191));
                default: write_sizes(svg_pkg::RST_SCREEN_W, svg_pkg::RST_SCREEN_H,
                                     svg_pkg::RST_TEXTURE_W, svg_pkg::RST_TEXTURE_H);
            endcase
            send_idle_pct = idle_modes[ph % 5][0];
            recv_stall_pct = idle_modes[ph % 5][1];
            for (int n = 0; n < 19; n++)
                pending_sprites.push_back(rand_sprite($urandom_range(3) == 0));
        end

        wait_drained();
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== sprite_quad_vertex_generator.f =====
design/svg_pkg.sv
design/svg_div.sv
design/svg_fifo.sv
design/svg_front.sv
design/svg_back.sv
design/sprite_quad_vertex_generator.sv
tb/tb_sprite_quad_vertex_generator.sv
